[rtl/core/rgt_pkg.sv]
// ----------------------------------------------------------------------------
// Rectangle grid tiler package
// Shared widths, status codes and the serial divider interface types.
// ----------------------------------------------------------------------------
package rgt_pkg;

    localparam int MaxParts = 64;
    localparam int CntW     = 7;   // holds 0..127
    localparam int QuoW     = 64;  // widest dividend (box area)
    localparam int DivW     = 48;  // widest divisor (largest tile area)

    localparam logic [1:0] StatusOk       = 2'd0;
    localparam logic [1:0] StatusInvalid  = 2'd1;
    localparam logic [1:0] StatusTooMany  = 2'd2;

    typedef struct packed {
        logic            start;
        logic [QuoW-1:0] dividend;
        logic [DivW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic            busy;
        logic            done;
        logic [QuoW-1:0] quotient;
        logic [DivW-1:0] remainder;
    } t_div_rsp;

endpackage

[rtl/core/rgt_divider.sv]
// ----------------------------------------------------------------------------
// Rectangle grid tiler serial divider
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module rgt_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rgt_pkg::t_div_req  i_req,
    output rgt_pkg::t_div_rsp  o_rsp
);

    logic [rgt_pkg::QuoW-1:0] r_quo, n_quo;
    logic [rgt_pkg::DivW:0]   r_rem, n_rem;
    logic [rgt_pkg::DivW-1:0] r_dvs, n_dvs;
    logic [6:0]               r_cnt, n_cnt;
    logic                     r_busy, n_busy;
    logic                     r_done, n_done;
    logic [rgt_pkg::DivW:0]   w_sh;

    assign w_sh = {r_rem[rgt_pkg::DivW-1:0], r_quo[rgt_pkg::QuoW-1]};

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
            n_cnt  = 7'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_dvs}) begin
                n_rem = w_sh - {1'b0, r_dvs};
                n_quo = {r_quo[rgt_pkg::QuoW-2:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_quo = {r_quo[rgt_pkg::QuoW-2:0], 1'b0};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'(rgt_pkg::QuoW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_cnt <= n_cnt;
    end

    assign o_rsp.busy      = r_busy;
    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem[rgt_pkg::DivW-1:0];

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("divider done held");
    a_not_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_done && r_busy)) else $error("divider done while busy");
`endif

endmodule

[rtl/core/rectangle_grid_tiler_top.sv]
// ----------------------------------------------------------------------------
// Rectangle grid tiler
// Splits a box into a grid of tiles of near-equal size, one tile a beat.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Beat carries
//  input     in         i_valid / o_ready    mode, box, part count, max area
//  output    out        o_valid / i_ready    tile index, tile box, status, last
//
//  A request is taken only when the block is idle; o_ready is low until the
//  final beat of the previous request has been taken.
//  Every division runs through one shared serial divider: the area
//  mode count, each trial divisor of the factor search (up to 8 of them) and
//  both edges of each row and each column.
//  Reset is synchronous and active low and returns the sequencer to idle.
//  A stalled output beat simply holds; nothing else advances meanwhile.
// ----------------------------------------------------------------------------
module rectangle_grid_tiler_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic signed [31:0] i_min_x,
    input  logic signed [31:0] i_min_y,
    input  logic signed [31:0] i_max_x,
    input  logic signed [31:0] i_max_y,
    input  logic [7:0]  i_part_count,
    input  logic [47:0] i_max_sub_area,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_tile_index,
    output logic signed [31:0] o_tile_min_x,
    output logic signed [31:0] o_tile_min_y,
    output logic signed [31:0] o_tile_max_x,
    output logic signed [31:0] o_tile_max_y,
    output logic [1:0]  o_status,
    output logic        o_last
);

    // Sequencer states, one-hot.
    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_CHECK  = 11'b00000000010,
        S_AREA   = 11'b00000000100,
        S_ADIV   = 11'b00000001000,
        S_COUNT  = 11'b00000010000,
        S_FTRY   = 11'b00000100000,
        S_FWAIT  = 11'b00001000000,
        S_YDIV   = 11'b00010000000,
        S_XDIV   = 11'b00100000000,
        S_EMIT   = 11'b01000000000,
        S_MUL    = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    // Request registers.
    logic                r_mode;
    logic signed [31:0]  r_x0, r_y0, r_x1, r_y1;
    logic [7:0]          r_pc;
    logic [47:0]         r_ma;
    logic [31:0]         r_dx, r_dy;
    logic [63:0]         r_area;
    logic [63:0]         r_n;
    logic [rgt_pkg::CntW-1:0] r_best, r_try, r_rows, r_cols, r_row, r_col;
    logic [rgt_pkg::CntW-1:0] r_bquo;   // n divided by the best factor so far
    logic                r_hi;       // set for the upper edge of the current row or column
    logic [31:0]         r_e0, r_e1; // y edge offsets of current row
    logic [31:0]         r_f0;       // x lower offset
    logic                r_ov;
    logic [5:0]          r_oidx;
    logic signed [31:0]  r_ox0, r_oy0, r_ox1, r_oy1;
    logic [1:0]          r_ost;
    logic                r_olast;
    logic                r_wait;     // divider launched, awaiting done

    rgt_pkg::t_div_req w_req;
    rgt_pkg::t_div_rsp w_rsp;

    rgt_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Edge multiplier: k * length, k at most 64, one product per launch.
    logic [rgt_pkg::CntW-1:0] w_k;
    logic [31:0]              w_len;
    logic [38:0]              w_prod;
    logic [rgt_pkg::CntW-1:0] w_div;
    assign w_prod = {32'd0, w_k} * {7'd0, w_len};

    always_comb begin
        if (r_state == S_YDIV) begin
            w_k   = r_hi ? r_row + 7'd1 : r_row;
            w_len = r_dy;
            w_div = r_rows;
        end else begin
            w_k   = r_hi ? r_col + 7'd1 : r_col;
            w_len = r_dx;
            w_div = r_cols;
        end
    end

    // The factor search stops once the trial divisor squared passes n.
    logic [13:0] w_sq;
    logic        w_search_done;
    assign w_sq          = {7'd0, r_try} * {7'd0, r_try};
    assign w_search_done = ({50'd0, w_sq} > r_n);

    logic signed [32:0] w_ddx, w_ddy;
    assign w_ddx = {r_x1[31], r_x1} - {r_x0[31], r_x0};
    assign w_ddy = {r_y1[31], r_y1} - {r_y0[31], r_y0};

    // Request checks: an inverted box or a zero count or area is invalid,
    // a box that already fits the area limit goes out whole.
    logic w_bad, w_fits, w_too_many;
    assign w_bad      = w_ddx[32] || w_ddy[32] ||
                        (r_mode ? (r_ma == '0) : (r_pc == '0));
    assign w_fits     = (r_area <= {16'd0, r_ma});
    assign w_too_many = (r_n > 64'(rgt_pkg::MaxParts));

    logic w_in_acc, w_out_acc;
    assign w_in_acc  = i_valid && o_ready;
    assign w_out_acc = r_ov && i_ready;
    assign o_ready   = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        w_req   = '0;
        case (r_state)
            S_IDLE:  if (w_in_acc) n_state = S_CHECK;
            S_CHECK: n_state = w_bad ? S_EMIT : S_MUL;
            S_MUL:   n_state = r_mode ? S_AREA : S_COUNT;
            S_AREA:  begin
                if (w_fits) begin
                    n_state = S_EMIT;
                end else begin
                    w_req.start    = 1'b1;
                    w_req.dividend = r_area;
                    w_req.divisor  = r_ma;
                    n_state        = S_ADIV;
                end
            end
            S_ADIV:  if (w_rsp.done) n_state = S_COUNT;
            S_COUNT: n_state = w_too_many ? S_EMIT : S_FTRY;
            S_FTRY:  begin
                if (w_search_done) begin
                    n_state = S_YDIV;
                end else begin
                    w_req.start    = 1'b1;
                    w_req.dividend = r_n;
                    w_req.divisor  = {41'd0, r_try};
                    n_state        = S_FWAIT;
                end
            end
            S_FWAIT: if (w_rsp.done) n_state = S_FTRY;
            S_YDIV, S_XDIV: begin
                w_req.start    = !r_wait;
                w_req.dividend = {25'd0, w_prod};
                w_req.divisor  = {41'd0, w_div};
                if (r_wait && w_rsp.done && r_hi)
                    n_state = (r_state == S_YDIV) ? S_XDIV : S_EMIT;
            end
            S_EMIT:  begin
                if (w_out_acc) begin
                    if (r_olast) n_state = S_IDLE;
                    else if (r_col + 7'd1 == r_cols) n_state = S_YDIV;
                    else n_state = S_XDIV;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_wait  <= 1'b0;
        end else begin
            if (w_out_acc) r_ov <= 1'b0;
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    r_mode <= i_mode;
                    r_x0 <= i_min_x; r_y0 <= i_min_y;
                    r_x1 <= i_max_x; r_y1 <= i_max_y;
                    r_pc <= i_part_count; r_ma <= i_max_sub_area;
                end
                S_CHECK: begin
                    r_dx <= w_ddx[31:0];
                    r_dy <= w_ddy[31:0];
                    r_ox0 <= '0; r_oy0 <= '0; r_ox1 <= '0; r_oy1 <= '0;
                    r_oidx <= '0; r_olast <= 1'b1;
                    if (w_bad) begin
                        r_ost <= rgt_pkg::StatusInvalid;
                        r_ov  <= 1'b1;
                    end
                end
                S_MUL: begin
                    // 32 x 32 product of the two lengths.
                    r_area <= {32'd0, r_dx} * {32'd0, r_dy};
                    r_n    <= {56'd0, r_pc};
                end
                S_AREA: begin
                    if (w_fits) begin
                        r_ox0 <= r_x0; r_oy0 <= r_y0;
                        r_ox1 <= r_x1; r_oy1 <= r_y1;
                        r_ost <= rgt_pkg::StatusOk;
                        r_ov  <= 1'b1;
                    end
                end
                S_ADIV: if (w_rsp.done)
                    r_n <= w_rsp.quotient + {63'd0, (w_rsp.remainder != '0)};
                S_COUNT: begin
                    r_best <= 7'd1;
                    r_bquo <= r_n[6:0];
                    r_try  <= 7'd1;
                    if (w_too_many) begin
                        r_ost <= rgt_pkg::StatusTooMany;
                        r_ov  <= 1'b1;
                    end
                end
                S_FTRY: if (w_search_done) begin
                    // search finished: orient the grid
                    if (r_dx >= r_dy && r_dx != '0) begin
                        r_rows <= r_best;
                        r_cols <= r_bquo;
                    end else begin
                        r_cols <= r_best;
                        r_rows <= r_bquo;
                    end
                    r_row <= '0; r_col <= '0; r_hi <= 1'b0; r_wait <= 1'b0;
                end
                S_FWAIT: if (w_rsp.done) begin
                    if (w_rsp.remainder == '0) begin
                        r_best <= r_try;
                        r_bquo <= w_rsp.quotient[6:0];
                    end
                    r_try <= r_try + 7'd1;
                end
                S_YDIV, S_XDIV: begin
                    if (!r_wait) r_wait <= 1'b1;
                    else if (w_rsp.done) begin
                        r_wait <= 1'b0;
                        r_hi   <= !r_hi;
                        if (r_state == S_YDIV) begin
                            if (!r_hi) r_e0 <= w_rsp.quotient[31:0];
                            else r_e1 <= w_rsp.quotient[31:0];
                        end else begin
                            if (!r_hi) r_f0 <= w_rsp.quotient[31:0];
                            else begin
                                r_ox0  <= r_x0 + $signed(r_f0);
                                r_ox1  <= r_x0 + $signed(w_rsp.quotient[31:0]);
                                r_oy0  <= r_y0 + $signed(r_e0);
                                r_oy1  <= r_y0 + $signed(r_e1);
                                r_oidx <= 6'(r_row * r_cols + r_col);
                                r_ost  <= rgt_pkg::StatusOk;
                                r_olast <= (r_row + 7'd1 == r_rows) &&
                                           (r_col + 7'd1 == r_cols);
                                r_ov   <= 1'b1;
                            end
                        end
                    end
                end
                S_EMIT: begin
                    if (w_out_acc && !r_olast) begin
                        if (r_col + 7'd1 == r_cols) begin
                            r_col <= '0;
                            r_row <= r_row + 7'd1;
                        end else begin
                            r_col <= r_col + 7'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid      = r_ov;
    assign o_tile_index = r_oidx;
    assign o_tile_min_x = r_ox0;
    assign o_tile_min_y = r_oy0;
    assign o_tile_max_x = r_ox1;
    assign o_tile_max_y = r_oy1;
    assign o_status     = r_ost;
    assign o_last       = r_olast;

`ifndef SYNTHESIS
    a_valid_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> r_state == S_EMIT) else $error("result outside emit");
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && r_olast) |=> o_ready) else $error("not idle after last");
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ost != rgt_pkg::StatusOk) |-> r_olast)
        else $error("error result not last");
    a_trial_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FWAIT) |-> (w_rsp.busy || w_rsp.done))
        else $error("factor trial without divider activity");
`endif

endmodule

[test/rectangle_grid_tiler_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rectangle grid tiler testbench
// Sends directed and random tiling requests with bursty input and a stalling
// output, predicts every tile in a scoreboard and checks each output beat.
// ----------------------------------------------------------------------------
module rectangle_grid_tiler_top_test;

    typedef struct packed {
        logic [5:0]         idx;
        logic signed [31:0] x0;
        logic signed [31:0] y0;
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic [1:0]         status;
        logic               last;
    } t_tile;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
        logic [7:0]         count;
        logic [47:0]        max_area;
    } t_request;

    // The scoreboard holds the tiles still owed by the block, oldest first.
    class tile_scoreboard;
        t_tile pending_tiles[$];
        int    mismatches;

        function void push_tile(logic [5:0] idx, longint x0, longint y0,
                                longint x1, longint y1,
                                logic [1:0] status, logic last);
            t_tile t;
            t.idx = idx;
            t.x0 = x0[31:0];
            t.y0 = y0[31:0];
            t.x1 = x1[31:0];
            t.y1 = y1[31:0];
            t.status = status;
            t.last = last;
            pending_tiles = {pending_tiles, t};
        endfunction

        // Works out every tile a request should produce.
        function void note_request(t_request rq);
            longint x0, y0, x1, y1;
            longint unsigned dx, dy, n, best, rows, cols, area;
            x0 = rq.min_x;
            y0 = rq.min_y;
            x1 = rq.max_x;
            y1 = rq.max_y;
            if (x1 < x0 || y1 < y0) begin
                push_tile(6'd0, 0, 0, 0, 0, rgt_pkg::StatusInvalid, 1'b1);
                return;
            end
            dx = x1 - x0;
            dy = y1 - y0;
            if (rq.mode) begin
                if (rq.max_area == 0) begin
                    push_tile(6'd0, 0, 0, 0, 0, rgt_pkg::StatusInvalid, 1'b1);
                    return;
                end
                area = dx * dy;
                if (area <= rq.max_area) begin
                    push_tile(6'd0, x0, y0, x1, y1, rgt_pkg::StatusOk, 1'b1);
                    return;
                end
                n = area / rq.max_area;
                if (area % rq.max_area != 0) n++;
            end else begin
                n = 64'(rq.count);
                if (n == 0) begin
                    push_tile(6'd0, 0, 0, 0, 0, rgt_pkg::StatusInvalid, 1'b1);
                    return;
                end
            end
            if (n > rgt_pkg::MaxParts) begin
                push_tile(6'd0, 0, 0, 0, 0, rgt_pkg::StatusTooMany, 1'b1);
                return;
            end
            best = 1;
            for (longint unsigned i = 1; i * i <= n; i++)
                if (n % i == 0) best = i;
            // The larger factor runs along the longer side.
            if (dx >= dy && dx != 0) begin
                cols = n / best;
                rows = best;
            end else begin
                cols = best;
                rows = n / best;
            end
            for (longint unsigned r = 0; r < rows; r++)
                for (longint unsigned c = 0; c < cols; c++)
                    push_tile(6'(r * cols + c),
                              x0 + longint'((c * dx) / cols),
                              y0 + longint'((r * dy) / rows),
                              x0 + longint'(((c + 1) * dx) / cols),
                              y0 + longint'(((r + 1) * dy) / rows),
                              rgt_pkg::StatusOk,
                              (r + 1 == rows) && (c + 1 == cols));
        endfunction

        function void check_tile(t_tile got);
            t_tile want;
            if (pending_tiles.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected output beat: %p", got);
                return;
            end
            want = pending_tiles.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Tile mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic               i_mode;
    logic signed [31:0] i_min_x, i_min_y, i_max_x, i_max_y;
    logic [7:0]         i_part_count;
    logic [47:0]        i_max_sub_area;
    logic               o_valid;
    logic               i_ready;
    logic [5:0]         o_tile_index;
    logic signed [31:0] o_tile_min_x, o_tile_min_y, o_tile_max_x, o_tile_max_y;
    logic [1:0]         o_status;
    logic               o_last;

    tile_scoreboard tiles = new();
    t_request       directed_reqs[$];

    rectangle_grid_tiler_top uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard limit: requests are slow, all the more with output stalls, so 300 ms
    // covers the whole run many times.
    initial begin
        #300ms;
        $display("FAIL");
        $finish;
    end

    // Every beat accepted on the output is checked on the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            tiles.check_tile({o_tile_index, o_tile_min_x, o_tile_min_y,
                              o_tile_max_x, o_tile_max_y, o_status, o_last});
    end

    // The receiver stalls on its own pattern: a stretch of steady acceptance
    // now and then, otherwise ready is drawn at random each cycle.
    initial begin
        int steady;
        i_ready = 1'b0;
        steady = 0;
        forever begin
            @(negedge i_clk);
            if (steady > 0) begin
                steady--;
                i_ready <= 1'b1;
            end else if ($urandom_range(0, 40) == 0) begin
                steady = $urandom_range(20, 200);
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // Presents one request and holds it until the handshake completes. Valid
    // is raised at a falling edge and the beat is taken at the next rising
    // edge with ready high.
    task automatic send_request(t_request rq);
        i_valid        <= 1'b1;
        i_mode         <= rq.mode;
        i_min_x        <= rq.min_x;
        i_min_y        <= rq.min_y;
        i_max_x        <= rq.max_x;
        i_max_y        <= rq.max_y;
        i_part_count   <= rq.count;
        i_max_sub_area <= rq.max_area;
        do @(posedge i_clk); while (!o_ready);
        tiles.note_request(rq);
        @(negedge i_clk);
    endtask

    // Gaps between bursts; inside a burst valid stays high across requests.
    int burst_left;
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 150)) @(negedge i_clk);
            burst_left = $urandom_range(0, 6);
        end
    endtask

    function automatic t_request make_box(logic mode, longint x0, longint y0,
                                          longint w, longint h, int unsigned cnt,
                                          longint unsigned area);
        t_request rq;
        rq.mode = mode;
        rq.min_x = x0[31:0];
        rq.min_y = y0[31:0];
        rq.max_x = 32'(x0 + w);
        rq.max_y = 32'(y0 + h);
        rq.count = cnt[7:0];
        rq.max_area = area[47:0];
        return rq;
    endfunction

    function void add_directed(t_request rq);
        directed_reqs = {directed_reqs, rq};
    endfunction

    function automatic t_request random_request();
        t_request rq;
        longint   x0, y0, w, h;
        int       kind;
        kind = $urandom_range(0, 9);
        // Mostly well-placed boxes with small lengths, sometimes full range.
        if ($urandom_range(0, 4) == 0) begin
            x0 = longint'($signed($urandom()));
            y0 = longint'($signed($urandom()));
            w  = $urandom_range(0, 32'h7fffffff);
            h  = $urandom_range(0, 32'h7fffffff);
            if (x0 + w > 64'sh7fffffff) x0 = 64'sh7fffffff - w;
            if (y0 + h > 64'sh7fffffff) y0 = 64'sh7fffffff - h;
        end else begin
            x0 = longint'($signed($urandom())) >>> $urandom_range(4, 20);
            y0 = longint'($signed($urandom())) >>> $urandom_range(4, 20);
            w  = $urandom_range(0, 1 << $urandom_range(0, 20));
            h  = $urandom_range(0, 1 << $urandom_range(0, 20));
        end
        rq = make_box(kind < 5, x0, y0, w, h, $urandom_range(1, 64), 0);
        if (rq.mode) begin
            // Aim the area limit so that the tile count lands near 1..70.
            rq.max_area = 48'((longint'(w) * h) / $urandom_range(1, 70) + 1);
            if ($urandom_range(0, 15) == 0)
                rq.max_area = {$urandom(), 16'($urandom())};
        end else if (kind == 5) begin
            rq.count = 8'($urandom_range(0, 255));
        end
        // Some inverted boxes as noise.
        if (kind == 9) begin
            if ($urandom_range(0, 1)) rq.max_x = 32'(x0 - 1 - $urandom_range(0, 99));
            else rq.max_y = 32'(y0 - 1 - $urandom_range(0, 99));
        end
        // Unused field still gets random bits.
        if (rq.mode) rq.count = 8'($urandom());
        else rq.max_area = {$urandom(), 16'($urandom())};
        return rq;
    endfunction

    initial begin
        int quiet;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_mode = 1'b0;
        i_min_x = '0;
        i_min_y = '0;
        i_max_x = '0;
        i_max_y = '0;
        i_part_count = '0;
        i_max_sub_area = '0;
        burst_left = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: the counts at the edges, a prime, both orientations,
        // a square box, degenerate boxes, error cases and the area mode.
        add_directed(make_box(0, 0, 0, 1000, 500, 1, 0));
        add_directed(make_box(0, 0, 0, 1000, 500, 6, 0));
        add_directed(make_box(0, 0, 0, 500, 1000, 6, 0));
        add_directed(make_box(0, -300, -300, 600, 600, 7, 0));
        add_directed(make_box(0, 10, 20, 777, 333, 64, 0));
        add_directed(make_box(0, 10, 20, 777, 333, 65, 0));
        add_directed(make_box(0, 10, 20, 777, 333, 255, 0));
        add_directed(make_box(0, 10, 20, 777, 333, 0, 0));
        add_directed(make_box(0, 0, 0, 0, 0, 12, 0));
        add_directed(make_box(0, 5, 5, 0, 90, 8, 0));
        add_directed(make_box(0, 5, 5, 90, 0, 8, 0));
        add_directed(make_box(0, -2147483648, -2147483648,
                              64'hffffffff, 64'hffffffff, 48, 0));
        add_directed(make_box(1, -2147483648, -2147483648,
                              64'hffffffff, 64'hffffffff, 0, 48'hffffffffffff));
        add_directed(make_box(1, -2147483648, -2147483648,
                              64'hffffffff, 64'hffffffff, 0,
                              64'hfffffffe00000001 / 40 + 1));
        add_directed(make_box(1, 0, 0, 100, 100, 0, 0));
        add_directed(make_box(1, 0, 0, 100, 100, 0, 10000));
        add_directed(make_box(1, 0, 0, 100, 100, 0, 2500));
        add_directed(make_box(1, 0, 0, 100, 100, 0, 2499));
        add_directed(make_box(1, 0, 0, 100, 100, 0, 1));
        add_directed(make_box(1, 0, 0, 0, 0, 0, 1));
        add_directed(make_box(0, 100, 0, -1, 50, 4, 0));
        add_directed(make_box(1, 0, 100, 50, -1, 0, 7));
        foreach (directed_reqs[j]) begin
            send_request(directed_reqs[j]);
            pace();
        end

        for (int j = 0; j < 140; j++) begin
            send_request(random_request());
            pace();
            // The sender waits once for the output to drain completely.
            if (j == 70) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
                while (tiles.pending_tiles.size() != 0) @(negedge i_clk);
            end
        end
        i_valid <= 1'b0;

        while (tiles.pending_tiles.size() != 0) @(negedge i_clk);
        // Watch for stray beats for a while after the last expected one.
        quiet = 0;
        while (quiet < 200) begin
            @(negedge i_clk);
            quiet++;
        end

        if (tiles.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
